// ===== hdl/mcc_pkg.sv =====
// Shared types and codes for the minimum coin change solver.
package mcc_pkg;

    // Field widths fixed by the interface
    localparam int COIN_W    = 12;
    localparam int AMT_IN_W  = 12;
    localparam int COUNT_W   = 12;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNREACH  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_COINS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    // Coin list update request
    typedef struct packed {
        logic              clear;
        logic              append;
        logic [COIN_W-1:0] coin;
    } coin_req_t;

    // Query request toward the row engine
    typedef struct packed {
        logic                run;
        logic                fail;
        logic [STATUS_W-1:0] fail_status;
        logic [AMT_IN_W-1:0] target;
    } query_req_t;

    // Result strobe and payload
    typedef struct packed {
        logic                valid;
        logic [COUNT_W-1:0]  min_coins;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// ===== hdl/mcc_coin_list.sv =====
// Coin denomination store with fill count and overflow flag.
module mcc_coin_list #(
    parameter int MAX_COINS = 16,
    parameter int IDX_W     = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1,
    parameter int CNT_W     = $clog2(MAX_COINS + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mcc_pkg::coin_req_t        req,
    input  logic [IDX_W-1:0]          rd_addr,
    output logic [mcc_pkg::COIN_W-1:0] rd_data,
    output logic [CNT_W-1:0]          coin_count,
    output logic                      overflow
);

    logic [mcc_pkg::COIN_W-1:0] store [MAX_COINS];
    logic [mcc_pkg::COIN_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic                       full;
    logic                       coin_ok;
    logic                       do_write;

    assign full     = (count_reg == CNT_W'(MAX_COINS));
    assign coin_ok  = (req.coin != '0);
    assign do_write = req.append && coin_ok && !full;

    // Update fill count and overflow flag
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (req.clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (req.append && coin_ok)
        begin
            if (full)
                ovf_next = 1'b1;
            else
                count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Write appended coin; the read data comes out through an output register
    always_ff @(posedge clk)
    begin
        if (do_write)
            store[count_reg[IDX_W-1:0]] <= req.coin;
        rd_data_reg <= store[rd_addr];
    end

    assign rd_data    = rd_data_reg;
    assign coin_count = count_reg;
    assign overflow   = ovf_reg;

endmodule

// ===== hdl/mcc_row_ram.sv =====
// Best-count row memory: one write port, two registered read ports.
module mcc_row_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 13
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    // Write and read; a read of the entry written in the same cycle returns old data
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== hdl/mcc_row_engine.sv =====
// Sequencer that seeds and relaxes the best-count row for one query.
module mcc_row_engine #(
    parameter int MAX_COINS   = 16,
    parameter int AMOUNT_BITS = 12,
    parameter int IDX_W       = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1,
    parameter int CNT_W       = $clog2(MAX_COINS + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mcc_pkg::query_req_t        query,
    input  logic [CNT_W-1:0]           coin_count,
    output logic [IDX_W-1:0]           coin_addr,
    input  logic [mcc_pkg::COIN_W-1:0] coin_data,
    output logic                       row_we,
    output logic [AMOUNT_BITS-1:0]     row_waddr,
    output logic [AMOUNT_BITS:0]       row_wdata,
    output logic [AMOUNT_BITS-1:0]     row_raddr_a,
    output logic [AMOUNT_BITS-1:0]     row_raddr_b,
    input  logic [AMOUNT_BITS:0]       row_rdata_a,
    input  logic [AMOUNT_BITS:0]       row_rdata_b,
    output logic                       busy,
    output mcc_pkg::result_t           res
);

    localparam int ROW_W = AMOUNT_BITS + 1;
    localparam int CMP_W = (AMOUNT_BITS > mcc_pkg::COIN_W) ? AMOUNT_BITS : mcc_pkg::COIN_W;
    localparam int EXT_W = ROW_W + mcc_pkg::COUNT_W;
    localparam logic [ROW_W-1:0] NO_WAY = {1'b1, {AMOUNT_BITS{1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_SEED  = 3'd3;
    localparam logic [2:0] S_RELAX = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_NEXT  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // Control registers
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             b_valid_reg, b_valid_next;
    logic             res_valid_reg, res_valid_next;

    // Payload registers
    logic [AMOUNT_BITS-1:0]     target_reg, target_next;
    logic [mcc_pkg::COIN_W-1:0] coin_reg, coin_next;
    logic [AMOUNT_BITS-1:0]     j_reg, j_next;
    logic [mcc_pkg::COIN_W-1:0] rem_reg, rem_next;
    logic [AMOUNT_BITS-1:0]     quot_reg, quot_next;
    logic [ROW_W-1:0]           ans_reg, ans_next;
    logic [AMOUNT_BITS-1:0]     b_j_reg, b_j_next;
    logic                       b_fwd_reg, b_fwd_next;
    logic [ROW_W-1:0]           last_w_reg, last_w_next;
    logic [mcc_pkg::COUNT_W-1:0]  res_min_reg, res_min_next;
    logic [mcc_pkg::STATUS_W-1:0] res_st_reg, res_st_next;

    // Datapath helpers
    logic [CMP_W-1:0]       tgt_ext;
    logic [CMP_W-1:0]       coin_in_ext;
    logic [CMP_W-1:0]       coin_reg_ext;
    logic [CMP_W-1:0]       target_cmp;
    logic [AMOUNT_BITS-1:0] coin_amt;
    logic [ROW_W-1:0]       seed_val;
    logic                   seed_we;
    logic [ROW_W-1:0]       src;
    logic [ROW_W-1:0]       via;
    logic [ROW_W-1:0]       newv;
    logic [EXT_W-1:0]       ans_ext;

    assign tgt_ext      = CMP_W'(query.target);
    assign coin_in_ext  = CMP_W'(coin_data);
    assign coin_reg_ext = CMP_W'(coin_reg);
    assign target_cmp   = CMP_W'(target_reg);
    assign coin_amt     = coin_reg_ext[AMOUNT_BITS-1:0];
    assign ans_ext      = EXT_W'(ans_reg);

    // Seed value: exact multiple of the first coin, else no way
    assign seed_val = (rem_reg == '0) ? {1'b0, quot_reg} : NO_WAY;
    assign seed_we  = (state_reg == S_SEED);

    // Relax stage: forward the previous write when the coin is one
    assign src  = b_fwd_reg ? last_w_reg : row_rdata_b;
    assign via  = (src >= NO_WAY) ? NO_WAY : (src + ROW_W'(1));
    assign newv = (via < row_rdata_a) ? via : row_rdata_a;

    // Memory ports
    assign coin_addr   = k_reg[IDX_W-1:0];
    assign row_we      = seed_we || b_valid_reg;
    assign row_waddr   = b_valid_reg ? b_j_reg : j_reg;
    assign row_wdata   = b_valid_reg ? newv : seed_val;
    assign row_raddr_a = j_reg;
    assign row_raddr_b = j_reg - coin_amt;

    // Sequence the query
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        b_valid_next   = 1'b0;
        res_valid_next = 1'b0;
        target_next    = target_reg;
        coin_next      = coin_reg;
        j_next         = j_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        ans_next       = ans_reg;
        b_j_next       = b_j_reg;
        b_fwd_next     = 1'b0;
        last_w_next    = last_w_reg;
        res_min_next   = res_min_reg;
        res_st_next    = res_st_reg;

        // Retire the relax stage
        if (b_valid_reg)
        begin
            last_w_next = newv;
            if (b_j_reg == target_reg)
                ans_next = newv;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (query.run)
                begin
                    target_next = tgt_ext[AMOUNT_BITS-1:0];
                    k_next      = '0;
                    state_next  = S_FETCH;
                end
                else if (query.fail)
                begin
                    res_valid_next = 1'b1;
                    res_min_next   = '0;
                    res_st_next    = query.fail_status;
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                coin_next = coin_data;
                if (k_reg == '0)
                begin
                    j_next     = '0;
                    rem_next   = '0;
                    quot_next  = '0;
                    state_next = S_SEED;
                end
                else if (coin_in_ext > target_cmp)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    j_next     = coin_in_ext[AMOUNT_BITS-1:0];
                    state_next = S_RELAX;
                end
            end
            S_SEED:
            begin
                if (j_reg == target_reg)
                begin
                    ans_next   = seed_val;
                    state_next = S_NEXT;
                end
                else
                begin
                    j_next = j_reg + AMOUNT_BITS'(1);
                    if (rem_reg == coin_reg - mcc_pkg::COIN_W'(1))
                    begin
                        rem_next  = '0;
                        quot_next = quot_reg + AMOUNT_BITS'(1);
                    end
                    else
                    begin
                        rem_next = rem_reg + mcc_pkg::COIN_W'(1);
                    end
                end
            end
            S_RELAX:
            begin
                b_valid_next = 1'b1;
                b_j_next     = j_reg;
                b_fwd_next   = (coin_reg == mcc_pkg::COIN_W'(1)) && b_valid_reg;
                if (j_reg == target_reg)
                    state_next = S_DRAIN;
                else
                    j_next = j_reg + AMOUNT_BITS'(1);
            end
            S_DRAIN:
            begin
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (k_reg + CNT_W'(1) == coin_count)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_FETCH;
                end
            end
            S_DONE:
            begin
                res_valid_next = 1'b1;
                if (ans_reg >= NO_WAY)
                begin
                    res_min_next = '0;
                    res_st_next  = mcc_pkg::ST_UNREACH;
                end
                else
                begin
                    res_min_next = ans_ext[mcc_pkg::COUNT_W-1:0];
                    res_st_next  = mcc_pkg::ST_OK;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            b_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            b_valid_reg   <= b_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        target_reg  <= target_next;
        coin_reg    <= coin_next;
        j_reg       <= j_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        ans_reg     <= ans_next;
        b_j_reg     <= b_j_next;
        b_fwd_reg   <= b_fwd_next;
        last_w_reg  <= last_w_next;
        res_min_reg <= res_min_next;
        res_st_reg  <= res_st_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign res.valid     = res_valid_reg;
    assign res.min_coins = res_min_reg;
    assign res.status    = res_st_reg;

endmodule

// ===== hdl/min_coin_change_solver.sv =====
// Top level of the minimum coin change solver.
//
// Usage: drive cmd, coin_value and target_amount with start; a request is
// taken at a rising edge where start is high and busy is low. cmd 0 clears
// the coin list and cmd 1 appends one coin (zero coins are dropped, coins
// past MAX_COINS are dropped and flag an overflow); both give no result.
// cmd 2 queries a target and gives exactly one result, shown on min_coins
// and status for one cycle with done high.
// A query on an empty or overflowed list answers in the next cycle.
// Otherwise the first coin seeds the row at one amount per cycle, and each
// further coin relaxes it at one amount per cycle through a read-modify-
// write pipeline on the row memory; further coins above the target are
// skipped. busy stays high while the row engine works on the query.
// The receiver cannot stall: done is a one-cycle strobe.
// Reset empties the coin list and clears the overflow flag; the row
// memory needs no clearing since every query rewrites it before use.
module min_coin_change_solver #(
    parameter int MAX_COINS   = 16,
    parameter int AMOUNT_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [mcc_pkg::CMD_W-1:0]      cmd,
    input  logic [mcc_pkg::COIN_W-1:0]     coin_value,
    input  logic [mcc_pkg::AMT_IN_W-1:0]   target_amount,
    output logic                           done,
    output logic [mcc_pkg::COUNT_W-1:0]    min_coins,
    output logic [mcc_pkg::STATUS_W-1:0]   status
);

    localparam int IDX_W = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int CNT_W = $clog2(MAX_COINS + 1);
    localparam int ROW_W = AMOUNT_BITS + 1;

    logic                       accept;
    logic                       q_hit;
    mcc_pkg::coin_req_t         coin_req;
    mcc_pkg::query_req_t        query;
    mcc_pkg::result_t           res;
    logic [IDX_W-1:0]           coin_addr;
    logic [mcc_pkg::COIN_W-1:0] coin_data;
    logic [CNT_W-1:0]           coin_count;
    logic                       overflow;
    logic                       row_we;
    logic [AMOUNT_BITS-1:0]     row_waddr;
    logic [ROW_W-1:0]           row_wdata;
    logic [AMOUNT_BITS-1:0]     row_raddr_a;
    logic [AMOUNT_BITS-1:0]     row_raddr_b;
    logic [ROW_W-1:0]           row_rdata_a;
    logic [ROW_W-1:0]           row_rdata_b;

    // Decode the request
    assign accept = start && !busy;
    assign q_hit  = accept && (cmd == mcc_pkg::CMD_QUERY);

    assign coin_req.clear  = accept && (cmd == mcc_pkg::CMD_CLEAR);
    assign coin_req.append = accept && (cmd == mcc_pkg::CMD_APPEND);
    assign coin_req.coin   = coin_value;

    assign query.run         = q_hit && (coin_count != '0) && !overflow;
    assign query.fail        = q_hit && ((coin_count == '0) || overflow);
    assign query.fail_status = (coin_count == '0) ? mcc_pkg::ST_NO_COINS
                                                  : mcc_pkg::ST_OVERFLOW;
    assign query.target      = target_amount;

    mcc_coin_list #(
        .MAX_COINS (MAX_COINS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_coin_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (coin_req),
        .rd_addr    (coin_addr),
        .rd_data    (coin_data),
        .coin_count (coin_count),
        .overflow   (overflow)
    );

    mcc_row_ram #(
        .ADDR_W (AMOUNT_BITS),
        .DATA_W (ROW_W)
    ) u_row_ram (
        .clk     (clk),
        .we      (row_we),
        .waddr   (row_waddr),
        .wdata   (row_wdata),
        .raddr_a (row_raddr_a),
        .raddr_b (row_raddr_b),
        .rdata_a (row_rdata_a),
        .rdata_b (row_rdata_b)
    );

    mcc_row_engine #(
        .MAX_COINS   (MAX_COINS),
        .AMOUNT_BITS (AMOUNT_BITS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_row_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .query       (query),
        .coin_count  (coin_count),
        .coin_addr   (coin_addr),
        .coin_data   (coin_data),
        .row_we      (row_we),
        .row_waddr   (row_waddr),
        .row_wdata   (row_wdata),
        .row_raddr_a (row_raddr_a),
        .row_raddr_b (row_raddr_b),
        .row_rdata_a (row_rdata_a),
        .row_rdata_b (row_rdata_b),
        .busy        (busy),
        .res         (res)
    );

    assign done      = res.valid;
    assign min_coins = res.min_coins;
    assign status    = res.status;

    // A query on an empty list answers in the next cycle with no coins
    a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
        (q_hit && (coin_count == '0)) |=> (done && (status == mcc_pkg::ST_NO_COINS)))
        else $error("empty-list query did not answer with no-coins status");

    // A failed status carries a zero count
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != mcc_pkg::ST_OK)) |-> (min_coins == '0))
        else $error("nonzero count with failed status");

    // Every finished query ends with a result
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("query finished without a result");

    // A result is shown only once the engine is free
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

endmodule

// ===== test/min_coin_change_solver_test.sv =====
// Self-checking testbench for the minimum coin change solver: directed and random requests.
module min_coin_change_solver_test;

    localparam int MAX_COINS   = 16;
    localparam int AMOUNT_BITS = 12;
    localparam int ROW_LEN     = 1 << AMOUNT_BITS;
    localparam int NO_WAY      = 1 << AMOUNT_BITS;
    localparam int TAIL_CYCLES = 64;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_REQS = 65;

    // The block ignores this command code
    localparam logic [mcc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [mcc_pkg::CMD_W-1:0]    op;
        logic [mcc_pkg::COIN_W-1:0]   coin;
        logic [mcc_pkg::AMT_IN_W-1:0] amount;
        int unsigned                  gap;
        bit                           drain;
    } request_t;

    typedef struct {
        logic [mcc_pkg::COUNT_W-1:0]  count;
        logic [mcc_pkg::STATUS_W-1:0] code;
    } answer_t;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          start         = 1'b0;
    logic [mcc_pkg::CMD_W-1:0]     cmd           = '0;
    logic [mcc_pkg::COIN_W-1:0]    coin_value    = '0;
    logic [mcc_pkg::AMT_IN_W-1:0]  target_amount = '0;
    logic                          busy;
    logic                          done;
    logic [mcc_pkg::COUNT_W-1:0]   min_coins;
    logic [mcc_pkg::STATUS_W-1:0]  status;

    // Pending requests, expected answers and run bookkeeping
    request_t        request_queue[$];
    answer_t         answer_queue[$];
    request_t        offered;
    answer_t         oldest_answer;
    int unsigned     gap_left      = 0;
    int unsigned     failure_count = 0;
    int unsigned     op_seen[4]    = '{default: 0};
    int unsigned     status_seen[4] = '{default: 0};
    bit              calm_stretch  = 1'b0;
    longint unsigned cycle_budget  = 0;
    longint unsigned cycle_limit   = 64'd100_000_000;
    longint unsigned cycle_count   = 0;

    // Shadow copy of the coin list and the best-count row
    logic [mcc_pkg::COIN_W-1:0] coin_list[MAX_COINS];
    int unsigned                coins_held   = 0;
    bit                         list_spilled = 1'b0;
    int unsigned                count_row[ROW_LEN];

    min_coin_change_solver #(
        .MAX_COINS   (MAX_COINS),
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .coin_value    (coin_value),
        .target_amount (target_amount),
        .done          (done),
        .min_coins     (min_coins),
        .status        (status)
    );

    always #5 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Random filler for a coin field
    function automatic logic [mcc_pkg::COIN_W-1:0] rand_coin();
        return mcc_pkg::COIN_W'($urandom_range(0, 4095));
    endfunction

    // Random filler for an amount field
    function automatic logic [mcc_pkg::AMT_IN_W-1:0] rand_amount();
        return mcc_pkg::AMT_IN_W'($urandom_range(0, 4095));
    endfunction

    // Apply one accepted request to the shadow state; push the answer a query gives
    task automatic predict_request(input request_t r);
        answer_t     a;
        int unsigned t;
        int unsigned first;
        int unsigned c;
        int unsigned via;
        op_seen[r.op]++;
        case (r.op)
            mcc_pkg::CMD_CLEAR:
            begin
                coins_held   = 0;
                list_spilled = 1'b0;
            end
            mcc_pkg::CMD_APPEND:
            begin
                if (r.coin != 0)
                begin
                    if (coins_held < MAX_COINS)
                    begin
                        coin_list[coins_held] = r.coin;
                        coins_held++;
                    end
                    else
                    begin
                        list_spilled = 1'b1;
                    end
                end
            end
            mcc_pkg::CMD_QUERY:
            begin
                a.count = '0;
                if (coins_held == 0)
                begin
                    a.code = mcc_pkg::ST_NO_COINS;
                end
                else if (list_spilled)
                begin
                    a.code = mcc_pkg::ST_OVERFLOW;
                end
                else
                begin
                    t     = 32'(r.amount) & (ROW_LEN - 1);
                    first = 32'(coin_list[0]);
                    // Seed the row from the first coin by exact division
                    for (int j = 0; j <= t; j++)
                        count_row[j] = (j % first == 0) ? j / first : NO_WAY;
                    // Relax the row with each further coin
                    for (int k = 1; k < coins_held; k++)
                    begin
                        c = 32'(coin_list[k]);
                        for (int j = c; j <= t; j++)
                        begin
                            via = count_row[j - c] + 1;
                            if (via > NO_WAY)
                                via = NO_WAY;
                            if (via < count_row[j])
                                count_row[j] = via;
                        end
                    end
                    if (count_row[t] >= NO_WAY)
                    begin
                        a.code = mcc_pkg::ST_UNREACH;
                    end
                    else
                    begin
                        a.code  = mcc_pkg::ST_OK;
                        a.count = count_row[t][mcc_pkg::COUNT_W-1:0];
                    end
                end
                answer_queue.push_back(a);
            end
            default: ;
        endcase
    endtask

    // Queue one request with a random lead-in gap and add its worst cost to the budget
    task automatic queue_request(input logic [mcc_pkg::CMD_W-1:0] op,
                                 input logic [mcc_pkg::COIN_W-1:0] coin,
                                 input logic [mcc_pkg::AMT_IN_W-1:0] amount,
                                 input bit drain);
        request_t    r;
        int unsigned roll;
        roll     = $urandom_range(0, 19);
        r.op     = op;
        r.coin   = coin;
        r.amount = amount;
        r.drain  = drain;
        if (calm_stretch || roll < 10)
            r.gap = 0;
        else if (roll < 18)
            r.gap = $urandom_range(1, 3);
        else
            r.gap = $urandom_range(10, 80);
        request_queue.push_back(r);
        cycle_budget += r.gap + 8;
        if (op == mcc_pkg::CMD_QUERY)
            cycle_budget += 16 + (MAX_COINS + 1) * (32'(amount) + 6);
    endtask

    task automatic note_failure(input string msg);
        failure_count++;
        if (failure_count <= MAX_REPORTS)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    // Driver: offer queued requests, hold while busy, idle between them
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_request(offered);
                if (request_queue.size() != 0)
                    gap_left = request_queue[0].gap;
            end
            if (!(start && busy))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (request_queue.size() != 0 &&
                         !(request_queue[0].drain && (answer_queue.size() != 0 || busy)))
                begin
                    offered        = request_queue.pop_front();
                    start         <= 1'b1;
                    cmd           <= offered.op;
                    coin_value    <= offered.coin;
                    target_amount <= offered.amount;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result strobe against the oldest expected answer
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (answer_queue.size() == 0)
            begin
                note_failure($sformatf("result with none expected: min_coins %0d status %0d",
                                       min_coins, status));
            end
            else
            begin
                oldest_answer = answer_queue.pop_front();
                status_seen[oldest_answer.code]++;
                if (min_coins !== oldest_answer.count || status !== oldest_answer.code)
                    note_failure($sformatf("min_coins exp %0d got %0d, status exp %0d got %0d",
                                           oldest_answer.count, min_coins,
                                           oldest_answer.code, status));
            end
        end
    end

    // Stop the run if it exceeds the cycle limit
    initial
    begin
        @(posedge clk);
        while (cycle_count < cycle_limit)
            @(posedge clk);
        $display("Run exceeded %0d cycles", cycle_limit);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int unsigned                  random_reqs;
        int unsigned                  n;
        logic [mcc_pkg::COIN_W-1:0]   coin;
        logic [mcc_pkg::AMT_IN_W-1:0] amount;

        // Directed: empty list, zero coin, extreme coin and targets
        queue_request(mcc_pkg::CMD_QUERY, rand_coin(), 12'hFFF, 1'b0);
        queue_request(mcc_pkg::CMD_APPEND, 12'd0, rand_amount(), 1'b0);
        queue_request(mcc_pkg::CMD_APPEND, 12'hFFF, 12'd0, 1'b0);
        queue_request(mcc_pkg::CMD_QUERY, 12'd0, 12'hFFF, 1'b0);
        queue_request(mcc_pkg::CMD_QUERY, rand_coin(), 12'd0, 1'b0);
        queue_request(mcc_pkg::CMD_QUERY, rand_coin(), 12'd2048, 1'b0);
        queue_request(mcc_pkg::CMD_APPEND, 12'd1, rand_amount(), 1'b0);
        queue_request(mcc_pkg::CMD_QUERY, rand_coin(), 12'd4094, 1'b0);
        queue_request(CMD_UNUSED, rand_coin(), rand_amount(), 1'b0);
        // Clear, then an empty-list query, unreachable and reachable targets
        queue_request(mcc_pkg::CMD_CLEAR, rand_coin(), rand_amount(), 1'b0);
        queue_request(mcc_pkg::CMD_QUERY, rand_coin(), 12'd5, 1'b0);
        queue_request(mcc_pkg::CMD_APPEND, 12'd3, rand_amount(), 1'b0);
        queue_request(mcc_pkg::CMD_APPEND, 12'd5, rand_amount(), 1'b0);
        queue_request(mcc_pkg::CMD_QUERY, rand_coin(), 12'd7, 1'b1);
        queue_request(mcc_pkg::CMD_QUERY, rand_coin(), 12'd11, 1'b0);
        // Fill the list, overflow it, and clear the overflow
        for (int k = 0; k < MAX_COINS - 2; k++)
            queue_request(mcc_pkg::CMD_APPEND, mcc_pkg::COIN_W'($urandom_range(6, 30)),
                          rand_amount(), 1'b0);
        queue_request(mcc_pkg::CMD_APPEND, 12'd7, rand_amount(), 1'b0);
        queue_request(mcc_pkg::CMD_QUERY, rand_coin(), rand_amount(), 1'b0);
        queue_request(mcc_pkg::CMD_CLEAR, rand_coin(), rand_amount(), 1'b0);
        queue_request(mcc_pkg::CMD_QUERY, rand_coin(), rand_amount(), 1'b0);

        // Random: mostly clear, load a few coins, then query; some noise mixed in
        random_reqs = 0;
        while (random_reqs < RANDOM_REQS)
        begin
            calm_stretch = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) != 0)
            begin
                queue_request(mcc_pkg::CMD_CLEAR, rand_coin(), rand_amount(), 1'b0);
                random_reqs++;
            end
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(14, 18);
            for (int k = 0; k < n; k++)
            begin
                coin = ($urandom_range(0, 5) == 0) ? mcc_pkg::COIN_W'($urandom_range(1, 4095))
                                                   : mcc_pkg::COIN_W'($urandom_range(1, 40));
                queue_request(mcc_pkg::CMD_APPEND, coin, rand_amount(), 1'b0);
                random_reqs++;
                if ($urandom_range(0, 11) == 0)
                    queue_request(mcc_pkg::CMD_APPEND, 12'd0, rand_amount(), 1'b0);
            end
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
            begin
                amount = ($urandom_range(0, 15) == 0)
                         ? mcc_pkg::AMT_IN_W'($urandom_range(0, 4095))
                         : mcc_pkg::AMT_IN_W'($urandom_range(0, 150));
                queue_request(mcc_pkg::CMD_QUERY, rand_coin(), amount,
                              $urandom_range(0, 9) == 0);
                random_reqs++;
            end
            if ($urandom_range(0, 7) == 0)
                queue_request(CMD_UNUSED, rand_coin(), rand_amount(), 1'b0);
        end
        cycle_limit = 4 * cycle_budget + 2000;

        // Hold reset, then release it
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Drain stimulus and answers, then let the block settle
        while (request_queue.size() != 0 || start)
            @(posedge clk);
        while (answer_queue.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d clears, %0d appends, %0d queries, %0d unused commands",
                 op_seen[mcc_pkg::CMD_CLEAR], op_seen[mcc_pkg::CMD_APPEND],
                 op_seen[mcc_pkg::CMD_QUERY], op_seen[CMD_UNUSED]);
        $display("Answers: %0d ok, %0d unreachable, %0d empty list, %0d overflowed list",
                 status_seen[mcc_pkg::ST_OK], status_seen[mcc_pkg::ST_UNREACH],
                 status_seen[mcc_pkg::ST_NO_COINS], status_seen[mcc_pkg::ST_OVERFLOW]);
        if (failure_count == 0 && answer_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
